[hdl/assert_macros.svh]
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

[hdl/lzw_pkg.sv]
package lzw_pkg;
    localparam int unsigned CODE_W = 12;
    localparam int unsigned KEY_W = 20;
    localparam logic [CODE_W-1:0] FIRST_LEARNED = 12'd257;
    localparam int unsigned OBUF_DEPTH = 5;
    localparam int unsigned OBUF_W = 3;
endpackage

[hdl/lzw_dict.sv]
module lzw_dict
    import lzw_pkg::*;
#(
    parameter int unsigned ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [KEY_W-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [KEY_W-1:0]  o_rdata
);
    logic [KEY_W-1:0] r_mem [0:(1<<ADDR_W)-1];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/lzw_compressor_12bit.sv]
// byte-serial lzw compressor, 12-bit codes packed two per three bytes
// input channel s_axis: tdata = in_byte,
//   tuser = in_last (1 marks the final byte of the stream)
// output channel m_axis: tdata = out_byte, tlast = run_end,
//   tuser = stream_end (last byte of the whole compressed stream)
// each request but the first byte of a stream starts a linear search of the
//   learned codes 257..next_code-1, one dictionary read and one key compare
//   per code through a single registered memory port
// afterwards 0 to 5 output bytes are drained one per cycle, while m_axis_tready
//   is high, from a small buffer; s_axis_tready stays low until they are all taken
// a miss with a full dictionary restarts learning at code 257
// the byte marked last flushes the final code, then all state returns to
//   reset so the next byte opens a new stream with an empty dictionary
// reset (i_rst_n low, synchronous) clears the sequencer and code state;
//   the dictionary memory needs no clearing since only written codes are read
// a stall on m_axis_tready simply holds the current byte
module lzw_compressor_12bit
    import lzw_pkg::*;
#(
    parameter int unsigned DICT_ENTRIES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
    input  logic       s_axis_tuser,  // [0] in_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser   // [0] stream_end
);
`include "assert_macros.svh"

    localparam int unsigned ADDR_W = $clog2(DICT_ENTRIES);
    localparam logic [CODE_W:0] LIMIT = (CODE_W+1)'(DICT_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_CMP, S_DONE, S_OUT
    } t_state;

    t_state r_state;
    logic [7:0]        r_byte;
    logic              r_last;
    logic [CODE_W:0]   r_next;
    logic [CODE_W-1:0] r_cur;
    logic              r_have;
    logic [CODE_W-1:0] r_pend;
    logic              r_pvalid;
    logic [CODE_W:0]   r_scan;
    logic              r_found;
    logic [7:0]        r_obuf [0:OBUF_DEPTH-1];
    logic [OBUF_W-1:0] r_ocnt;
    logic [OBUF_W-1:0] r_optr;

    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  rdata;
    logic              we;
    logic [ADDR_W-1:0] waddr;

    assign key   = {r_cur, r_byte};
    assign we    = (r_state == S_DONE) && r_have && !r_found;
    // a full dictionary restarts learning at the first learned code
    assign waddr = (r_next >= LIMIT) ? ADDR_W'(FIRST_LEARNED) : r_next[ADDR_W-1:0];

    lzw_dict #(.ADDR_W(ADDR_W)) u_dict (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(key),
        .i_raddr(r_scan[ADDR_W-1:0]),
        .o_rdata(rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_obuf[r_optr];
    assign m_axis_tlast  = (r_optr == r_ocnt - OBUF_W'(1));
    assign m_axis_tuser  = m_axis_tlast && r_last;

    // search, code emission into the byte buffer (up to two codes plus lone flush) and output drain
    always_ff @(posedge i_clk) begin
        logic [CODE_W-1:0] n_pend;
        logic              n_pvalid;
        logic [OBUF_W-1:0] n_ocnt;
        logic [CODE_W-1:0] n_cur;
        logic [CODE_W:0]   n_next;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_next   <= (CODE_W+1)'(FIRST_LEARNED);
            r_cur    <= '0;
            r_have   <= 1'b0;
            r_pend   <= '0;
            r_pvalid <= 1'b0;
            r_ocnt   <= '0;
            r_optr   <= '0;
            r_found  <= 1'b0;
            r_scan   <= '0;
            r_last   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_byte  <= s_axis_tdata;
                        r_last  <= s_axis_tuser;
                        r_scan  <= (CODE_W+1)'(FIRST_LEARNED);
                        r_found <= 1'b0;
                        r_state <= r_have ? S_READ : S_DONE;
                    end
                end
                S_READ: begin
                    if (r_scan >= r_next || r_next >= LIMIT) begin
                        if (r_scan >= LIMIT || (r_next < LIMIT && r_scan >= r_next)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_CMP;
                        end
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (rdata == key) begin
                        r_found <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_scan  <= r_scan + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    n_pend   = r_pend;
                    n_pvalid = r_pvalid;
                    n_ocnt   = '0;
                    n_cur    = r_cur;
                    n_next   = r_next;
                    if (!r_have) begin
                        n_cur = CODE_W'(r_byte);
                    end else if (r_found) begin
                        n_cur = r_scan[CODE_W-1:0];
                    end else begin
                        if (n_pvalid) begin
                            r_obuf[0] <= n_pend[11:4];
                            r_obuf[1] <= {n_pend[3:0], r_cur[11:8]};
                            r_obuf[2] <= r_cur[7:0];
                            n_ocnt   = OBUF_W'(3);
                            n_pvalid = 1'b0;
                        end else begin
                            n_pend   = r_cur;
                            n_pvalid = 1'b1;
                        end
                        if (r_next >= LIMIT) begin
                            n_next = (CODE_W+1)'(FIRST_LEARNED) + 1'b1;
                        end else begin
                            n_next = r_next + 1'b1;
                        end
                        n_cur = CODE_W'(r_byte);
                    end
                    if (r_last) begin
                        if (n_pvalid) begin
                            r_obuf[n_ocnt]               <= n_pend[11:4];
                            r_obuf[n_ocnt + OBUF_W'(1)]  <= {n_pend[3:0], n_cur[11:8]};
                            r_obuf[n_ocnt + OBUF_W'(2)]  <= n_cur[7:0];
                            n_ocnt = n_ocnt + OBUF_W'(3);
                        end else begin
                            r_obuf[n_ocnt]              <= {4'b0000, n_cur[11:8]};
                            r_obuf[n_ocnt + OBUF_W'(1)] <= n_cur[7:0];
                            n_ocnt = n_ocnt + OBUF_W'(2);
                        end
                        r_next   <= (CODE_W+1)'(FIRST_LEARNED);
                        r_cur    <= '0;
                        r_have   <= 1'b0;
                        r_pend   <= '0;
                        r_pvalid <= 1'b0;
                    end else begin
                        r_next   <= n_next;
                        r_cur    <= n_cur;
                        r_have   <= 1'b1;
                        r_pend   <= n_pend;
                        r_pvalid <= n_pvalid;
                    end
                    r_ocnt  <= n_ocnt;
                    r_optr  <= '0;
                    r_state <= (n_ocnt == '0) ? S_IDLE : S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        if (m_axis_tlast) begin
                            r_state <= S_IDLE;
                        end
                        r_optr <= r_optr + OBUF_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEVER(a_busy_io, s_axis_tready && m_axis_tvalid, "input and output both open")
    `ASSERT_CLK(a_ocnt_max, m_axis_tvalid |-> (r_ocnt <= OBUF_W'(OBUF_DEPTH)), "buffer overrun")
    `ASSERT_CLK(a_next_rng, r_next >= (CODE_W+1)'(FIRST_LEARNED), "next code below first learned")
endmodule
